// File: sv/acm_pkg.sv
// ----------------------------------------------------------------------------
// acm_pkg
// Shared types for the Aho-Corasick node matcher: item modes, sequencer
// states and the table write controls.
// ----------------------------------------------------------------------------
package acm_pkg;

  typedef enum logic [1:0] {
    MODE_EDGE  = 2'd0,
    MODE_FAIL  = 2'd1,
    MODE_OUT   = 2'd2,
    MODE_MATCH = 2'd3
  } acm_mode_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FETCH,
    S_SCAN,
    S_CMP,
    S_ORD,
    S_OPUT
  } acm_state_t;

  // write strobes into the table block
  typedef struct packed {
    logic clear;
    logic edge_we;
    logic fail_we;
    logic out_we;
  } acm_wr_t;

endpackage

// File: sv/aho_corasick_node_matcher.sv
// ----------------------------------------------------------------------------
// aho_corasick_node_matcher
// Aho-Corasick walk over graph node ids with on-line table loading.
// ----------------------------------------------------------------------------
// Usage: one input channel (in_valid/in_ready) carries load and match
// requests; one result channel (out_valid/out_ready) returns match results.
// Load requests (edge, failure link, output entry) write one table entry in
// the cycle they are accepted and give no result.
// A match request consumes one node id. A small sequencer walks the tables
// through one registered read port: a fetch step reads a state's counts,
// then a scan and a compare step per edge slot, repeated for each failure
// hop. Once the new state is known, each result takes a list entry read,
// then a load into the output register, and a node with no k-mer gives one
// no-match result. The last result is flagged with out_last_result.
// in_ready is high only while the sequencer is idle; it returns high as soon
// as the last result sits in the output register, so the next request may be
// taken while that result waits. A stalled receiver holds the sequencer in
// the result step with the result register full.
// After reset the block sweeps the count and failure tables to zero, one
// state per cycle, with in_ready low; the walk starts at the root.
// ----------------------------------------------------------------------------
module aho_corasick_node_matcher
  import acm_pkg::*;
#(
  parameter int NUM_STATES   = 1024,
  parameter int EDGE_SLOTS   = 4,
  parameter int MAX_OUTPUTS  = 8,
  parameter int KMER_SPACE   = 4096,
  parameter int NODE_ID_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [9:0]  in_state_index,
  input  logic [2:0]  in_slot,
  input  logic [31:0] in_node_id,
  input  logic [9:0]  in_target_state,
  input  logic [11:0] in_kmer_id,
  input  logic        in_restart,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [9:0]  out_new_state,
  output logic [11:0] out_matched_kmer,
  output logic        out_match_valid,
  output logic        out_last_result
);

  localparam int ST_W  = $clog2(NUM_STATES);
  localparam int SYM_W = (NODE_ID_BITS < 32) ? NODE_ID_BITS : 32;
  localparam int EC_W  = $clog2(EDGE_SLOTS + 1);
  localparam int OC_W  = $clog2(MAX_OUTPUTS + 1);
  localparam int HP_W  = ST_W + 1;

  acm_state_t state_r, state_nxt;

  logic [ST_W-1:0]  clr_r, clr_nxt;
  logic [ST_W-1:0]  walk_r, walk_nxt;
  logic [ST_W-1:0]  cur_r, cur_nxt;
  logic [HP_W-1:0]  hops_r, hops_nxt;
  logic [EC_W-1:0]  slot_r, slot_nxt;
  logic [OC_W-1:0]  oi_r, oi_nxt;
  logic [SYM_W-1:0] sym_r, sym_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [9:0]  out_state_r;
  logic [11:0] out_kmer_r;
  logic        out_mv_r;
  logic        out_last_r;

  acm_wr_t          wr;
  logic [ST_W-1:0]  wr_state;
  logic [EC_W-1:0]  ecnt_q;
  logic [ST_W-1:0]  fail_q;
  logic [OC_W-1:0]  ocnt_q;
  logic [SYM_W-1:0] esym_q;
  logic [ST_W-1:0]  echild_q;
  logic [11:0]      entry_q;

  logic accept;
  logic idx_ok, tgt_ok;
  logic slots_left, sym_hit, at_root, hop_limit;
  logic out_free, out_load, out_last;
  logic [HP_W-1:0] hops_inc;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign idx_ok   = 32'(in_state_index) < NUM_STATES;
  assign tgt_ok   = 32'(in_target_state) < NUM_STATES;

  assign slots_left = slot_r < ecnt_q;
  assign sym_hit    = esym_q == sym_r;
  assign at_root    = cur_r == '0;
  assign hops_inc   = hops_r + HP_W'(1);
  assign hop_limit  = hops_inc == HP_W'(NUM_STATES);
  assign out_free   = !out_valid_r || out_ready;
  assign out_last   = (ocnt_q == '0) || ((oi_r + OC_W'(1)) == ocnt_q);
  assign out_load   = (state_r == S_OPUT) && out_free;

  // table writes
  always_comb begin
    wr         = '0;
    wr.clear   = (state_r == S_CLEAR);
    wr_state   = wr.clear ? clr_r : ST_W'(in_state_index);
    if (accept) begin
      unique case (acm_mode_t'(in_mode))
        MODE_EDGE:  wr.edge_we = idx_ok && tgt_ok && (32'(in_slot) < EDGE_SLOTS);
        MODE_FAIL:  wr.fail_we = idx_ok && tgt_ok;
        MODE_OUT:   wr.out_we  = idx_ok && (32'(in_slot) < MAX_OUTPUTS)
                                 && (32'(in_kmer_id) < KMER_SPACE);
        MODE_MATCH: wr         = '0;
        default:    wr         = '0;
      endcase
    end
  end

  acm_tables #(
    .NUM_STATES  (NUM_STATES),
    .EDGE_SLOTS  (EDGE_SLOTS),
    .MAX_OUTPUTS (MAX_OUTPUTS),
    .NODE_ID_BITS(NODE_ID_BITS)
  ) u_tables (
    .clk      (clk),
    .wr       (wr),
    .wr_state (wr_state),
    .wr_slot  (in_slot),
    .wr_sym   (SYM_W'(in_node_id)),
    .wr_target(ST_W'(in_target_state)),
    .wr_kmer  (in_kmer_id),
    .rd_state (cur_r),
    .rd_eslot (slot_r),
    .rd_oslot (oi_r),
    .ecnt_q   (ecnt_q),
    .fail_q   (fail_q),
    .ocnt_q   (ocnt_q),
    .esym_q   (esym_q),
    .echild_q (echild_q),
    .entry_q  (entry_q)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_r == ST_W'(NUM_STATES - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (accept && acm_mode_t'(in_mode) == MODE_MATCH) state_nxt = S_FETCH;
      S_FETCH: state_nxt = S_SCAN;
      S_SCAN: begin
        if (slots_left) begin
          state_nxt = S_CMP;
        end else if (at_root) begin
          state_nxt = S_ORD;
        end else begin
          state_nxt = S_FETCH;
        end
      end
      S_CMP:   state_nxt = sym_hit ? S_ORD : S_SCAN;
      S_ORD:   state_nxt = S_OPUT;
      S_OPUT: begin
        if (out_free) state_nxt = out_last ? S_IDLE : S_ORD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath updates
  always_comb begin
    clr_nxt       = clr_r;
    walk_nxt      = walk_r;
    cur_nxt       = cur_r;
    hops_nxt      = hops_r;
    slot_nxt      = slot_r;
    oi_nxt        = oi_r;
    sym_nxt       = sym_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_CLEAR: clr_nxt = clr_r + ST_W'(1);
      S_IDLE: begin
        if (accept && acm_mode_t'(in_mode) == MODE_MATCH) begin
          cur_nxt  = in_restart ? '0 : walk_r;
          sym_nxt  = SYM_W'(in_node_id);
          hops_nxt = '0;
          slot_nxt = '0;
        end
      end
      S_FETCH: slot_nxt = '0;
      S_SCAN: begin
        if (!slots_left) begin
          oi_nxt = '0;
          if (at_root) begin
            walk_nxt = '0;
          end else begin
            // hop limit reached: fall back to checking the root
            cur_nxt  = hop_limit ? '0 : fail_q;
            hops_nxt = hops_inc;
          end
        end
      end
      S_CMP: begin
        if (sym_hit) begin
          cur_nxt  = echild_q;
          walk_nxt = echild_q;
          oi_nxt   = '0;
        end else begin
          slot_nxt = slot_r + EC_W'(1);
        end
      end
      S_ORD: ;
      S_OPUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          oi_nxt        = oi_r + OC_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      walk_r      <= '0;
      cur_r       <= '0;
      hops_r      <= '0;
      slot_r      <= '0;
      oi_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      walk_r      <= walk_nxt;
      cur_r       <= cur_nxt;
      hops_r      <= hops_nxt;
      slot_r      <= slot_nxt;
      oi_r        <= oi_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r <= sym_nxt;
    if (out_load) begin
      out_state_r <= 10'(cur_r);
      out_mv_r    <= ocnt_q != '0;
      out_kmer_r  <= (ocnt_q != '0) ? entry_q : 12'd0;
      out_last_r  <= out_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_new_state    = out_state_r;
  assign out_matched_kmer = out_kmer_r;
  assign out_match_valid  = out_mv_r;
  assign out_last_result  = out_last_r;

endmodule

// File: sv/acm_tables.sv
// ----------------------------------------------------------------------------
// acm_tables
// Automaton storage: edge slots, failure links, output lists and the
// per-state counts. One write and one registered read per table and cycle.
// ----------------------------------------------------------------------------
module acm_tables
  import acm_pkg::*;
#(
  parameter int NUM_STATES   = 1024,
  parameter int EDGE_SLOTS   = 4,
  parameter int MAX_OUTPUTS  = 8,
  parameter int NODE_ID_BITS = 32
) (
  input  logic                                  clk,
  input  acm_wr_t                               wr,
  input  logic [$clog2(NUM_STATES)-1:0]         wr_state,
  input  logic [2:0]                            wr_slot,
  input  logic [((NODE_ID_BITS < 32) ? NODE_ID_BITS : 32)-1:0] wr_sym,
  input  logic [$clog2(NUM_STATES)-1:0]         wr_target,
  input  logic [11:0]                           wr_kmer,
  input  logic [$clog2(NUM_STATES)-1:0]         rd_state,
  input  logic [$clog2(EDGE_SLOTS+1)-1:0]       rd_eslot,
  input  logic [$clog2(MAX_OUTPUTS+1)-1:0]      rd_oslot,
  output logic [$clog2(EDGE_SLOTS+1)-1:0]       ecnt_q,
  output logic [$clog2(NUM_STATES)-1:0]         fail_q,
  output logic [$clog2(MAX_OUTPUTS+1)-1:0]      ocnt_q,
  output logic [((NODE_ID_BITS < 32) ? NODE_ID_BITS : 32)-1:0] esym_q,
  output logic [$clog2(NUM_STATES)-1:0]         echild_q,
  output logic [11:0]                           entry_q
);

  localparam int ST_W  = $clog2(NUM_STATES);
  localparam int SYM_W = (NODE_ID_BITS < 32) ? NODE_ID_BITS : 32;
  localparam int EC_W  = $clog2(EDGE_SLOTS + 1);
  localparam int OC_W  = $clog2(MAX_OUTPUTS + 1);
  localparam int EA_N  = NUM_STATES * EDGE_SLOTS;
  localparam int OA_N  = NUM_STATES * MAX_OUTPUTS;
  localparam int EA_W  = $clog2(EA_N);
  localparam int OA_W  = $clog2(OA_N);

  logic [SYM_W-1:0] edge_sym_mem   [EA_N];
  logic [ST_W-1:0]  edge_child_mem [EA_N];
  logic [EC_W-1:0]  edge_cnt_mem   [NUM_STATES];
  logic [ST_W-1:0]  fail_mem       [NUM_STATES];
  logic [11:0]      entry_mem      [OA_N];
  logic [OC_W-1:0]  out_cnt_mem    [NUM_STATES];

  logic [EA_W-1:0] e_waddr, e_raddr;
  logic [OA_W-1:0] o_waddr, o_raddr;
  logic [EC_W-1:0] ecnt_wdata;
  logic [OC_W-1:0] ocnt_wdata;
  logic [ST_W-1:0] fail_wdata;

  assign e_waddr = EA_W'(wr_state) * EA_W'(EDGE_SLOTS) + EA_W'(wr_slot);
  assign e_raddr = EA_W'(rd_state) * EA_W'(EDGE_SLOTS) + EA_W'(rd_eslot);
  assign o_waddr = OA_W'(wr_state) * OA_W'(MAX_OUTPUTS) + OA_W'(wr_slot);
  assign o_raddr = OA_W'(rd_state) * OA_W'(MAX_OUTPUTS) + OA_W'(rd_oslot);

  assign ecnt_wdata = wr.clear ? '0 : EC_W'(wr_slot) + EC_W'(1);
  assign ocnt_wdata = wr.clear ? '0 : OC_W'(wr_slot) + OC_W'(1);
  assign fail_wdata = wr.clear ? '0 : wr_target;

  always_ff @(posedge clk) begin
    if (wr.edge_we) begin
      edge_sym_mem[e_waddr]   <= wr_sym;
      edge_child_mem[e_waddr] <= wr_target;
    end
    esym_q   <= edge_sym_mem[e_raddr];
    echild_q <= edge_child_mem[e_raddr];
  end

  always_ff @(posedge clk) begin
    if (wr.edge_we || wr.clear) begin
      edge_cnt_mem[wr_state] <= ecnt_wdata;
    end
    ecnt_q <= edge_cnt_mem[rd_state];
  end

  always_ff @(posedge clk) begin
    if (wr.fail_we || wr.clear) begin
      fail_mem[wr_state] <= fail_wdata;
    end
    fail_q <= fail_mem[rd_state];
  end

  always_ff @(posedge clk) begin
    if (wr.out_we) begin
      entry_mem[o_waddr] <= wr_kmer;
    end
    entry_q <= entry_mem[o_raddr];
  end

  always_ff @(posedge clk) begin
    if (wr.out_we || wr.clear) begin
      out_cnt_mem[wr_state] <= ocnt_wdata;
    end
    ocnt_q <= out_cnt_mem[rd_state];
  end

endmodule

// File: test/aho_corasick_node_matcher_test.sv
// ----------------------------------------------------------------------------
// aho_corasick_node_matcher_test
// Loads goto edges, failure links and k-mer lists into the matcher, walks
// node ids through it and checks every result against a behavioral model
// of the automaton kept in a scoreboard. Directed requests cover the table
// extremes, a root miss, the longest k-mer list and a failure-link loop.
// Random traffic then builds a small trie in order, with some noise, under
// three sender/receiver throttling mixes.
// ----------------------------------------------------------------------------

typedef struct packed {
  bit [9:0]  walk_st;
  bit [11:0] kmer;
  bit        hit;
  bit        last;
} kmer_hit_t;

class kmer_scoreboard;
  localparam int NUM_STATES  = 1024;
  localparam int EDGE_SLOTS  = 4;
  localparam bit [9:0] ROOT  = 10'd0;

  bit [31:0]   edge_sym [0:4095];
  bit [9:0]    edge_dst [0:4095];
  int unsigned edge_cnt [0:1023];
  bit [9:0]    fail_to  [0:1023];
  bit [11:0]   out_kmer [0:8191];
  int unsigned out_cnt  [0:1023];
  bit [9:0]    walk;
  kmer_hit_t   hits_due [$];
  int          errors;

  function bit find_edge(bit [9:0] st, bit [31:0] sym, output bit [9:0] child);
    child = ROOT;
    for (int i = 0; i < edge_cnt[st]; i++) begin
      if (edge_sym[{st, 2'(i)}] == sym) begin
        child = edge_dst[{st, 2'(i)}];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // goto, else chase failure links; a looped chain gives up after
  // NUM_STATES hops and falls back to the root's edges
  function bit [9:0] step_walk(bit [9:0] st, bit [31:0] sym);
    bit [9:0] child;
    int       hops;
    hops = 0;
    while (st != ROOT && hops < NUM_STATES) begin
      if (find_edge(st, sym, child)) return child;
      st = fail_to[st];
      hops++;
    end
    if (find_edge(ROOT, sym, child)) return child;
    return ROOT;
  endfunction

  function void note_request(acm_pkg::acm_mode_t mode, bit [9:0] sidx, bit [2:0] slot,
                             bit [31:0] node, bit [9:0] tgt, bit [11:0] kmer,
                             bit restart);
    kmer_hit_t h;
    case (mode)
      acm_pkg::MODE_EDGE: begin
        if (slot < EDGE_SLOTS) begin
          edge_sym[{sidx, slot[1:0]}] = node;
          edge_dst[{sidx, slot[1:0]}] = tgt;
          edge_cnt[sidx] = slot + 1;
        end
      end
      acm_pkg::MODE_FAIL: fail_to[sidx] = tgt;
      acm_pkg::MODE_OUT: begin
        out_kmer[{sidx, slot}] = kmer;
        out_cnt[sidx] = slot + 1;
      end
      default: begin
        if (restart) walk = ROOT;
        walk = step_walk(walk, node);
        if (out_cnt[walk] == 0) begin
          h = '{walk_st: walk, kmer: 12'd0, hit: 1'b0, last: 1'b1};
          hits_due = {hits_due, h};
        end else begin
          for (int i = 0; i < out_cnt[walk]; i++) begin
            h = '{walk_st: walk, kmer: out_kmer[{walk, 3'(i)}], hit: 1'b1,
                  last: (i + 1 == out_cnt[walk])};
            hits_due = {hits_due, h};
          end
        end
      end
    endcase
  endfunction

  task report_mismatch(string msg);
    errors++;
    $display("mismatch: %s", msg);
  endtask

  task check_hit(bit [9:0] st, bit [11:0] km, bit hit, bit last);
    kmer_hit_t want;
    if (hits_due.size() == 0) begin
      report_mismatch($sformatf("unexpected result state=%0d kmer=%0d", st, km));
      return;
    end
    want = hits_due.pop_front();
    if (st != want.walk_st)
      report_mismatch($sformatf("state %0d, want %0d", st, want.walk_st));
    if (km != want.kmer)
      report_mismatch($sformatf("matched_kmer %0d, want %0d", km, want.kmer));
    if (hit != want.hit)
      report_mismatch($sformatf("match_valid %0b, want %0b", hit, want.hit));
    if (last != want.last)
      report_mismatch($sformatf("last_result %0b, want %0b", last, want.last));
  endtask
endclass

module aho_corasick_node_matcher_test;
  import acm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 40000;
  localparam int ACTIVE      = 24;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_mode = MODE_EDGE;
  logic [9:0]  in_state_index = '0;
  logic [2:0]  in_slot = '0;
  logic [31:0] in_node_id = '0;
  logic [9:0]  in_target_state = '0;
  logic [11:0] in_kmer_id = '0;
  logic        in_restart = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [9:0]  out_new_state;
  logic [11:0] out_matched_kmer;
  logic        out_match_valid;
  logic        out_last_result;

  kmer_scoreboard board = new;
  int          send_idle_pct = 35;
  int          recv_idle_pct = 71;
  int          idle_cycles = 0;
  bit [3:0]    edge_done [0:1023];
  bit [7:0]    out_done  [0:1023];
  bit [31:0]   alphabet  [0:5] = '{32'h0, 32'hFFFF_FFFF, 32'h5, 32'hDEAD_BEEF,
                                   32'h1234_5678, 32'h8000_0001};

  aho_corasick_node_matcher dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_state_index   (in_state_index),
    .in_slot          (in_slot),
    .in_node_id       (in_node_id),
    .in_target_state  (in_target_state),
    .in_kmer_id       (in_kmer_id),
    .in_restart       (in_restart),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_new_state    (out_new_state),
    .out_matched_kmer (out_matched_kmer),
    .out_match_valid  (out_match_valid),
    .out_last_result  (out_last_result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_hit(out_new_state, out_matched_kmer, out_match_valid, out_last_result);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task send_request(acm_mode_t mode, bit [9:0] sidx, bit [2:0] slot, bit [31:0] node,
                    bit [9:0] tgt, bit [11:0] kmer, bit restart);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_mode         <= mode;
    in_state_index  <= sidx;
    in_slot         <= slot;
    in_node_id      <= node;
    in_target_state <= tgt;
    in_kmer_id      <= kmer;
    in_restart      <= restart;
    do @(posedge clk); while (in_ready !== 1'b1);
    board.note_request(mode, sidx, slot, node, tgt, kmer, restart);
    if (mode == MODE_EDGE && slot < 4) edge_done[sidx][slot[1:0]] = 1'b1;
    if (mode == MODE_OUT) out_done[sidx][slot] = 1'b1;
  endtask

  task wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.hits_due.size() != 0);
  endtask

  // any slot up to the first never-written one, so no count covers a hole
  function automatic bit [2:0] pick_slot(bit [7:0] done, int cap);
    int top;
    top = 0;
    while (top < cap - 1 && done[top]) top++;
    return 3'($urandom_range(top));
  endfunction

  task random_request();
    acm_mode_t mode;
    bit [9:0]  sidx;
    bit [9:0]  tgt;
    bit [2:0]  slot;
    bit [31:0] node;
    bit [11:0] kmer;
    bit        restart;
    int        roll;
    // unused fields carry noise
    sidx    = 10'($urandom);
    tgt     = 10'($urandom);
    slot    = 3'($urandom);
    node    = $urandom;
    kmer    = 12'($urandom);
    restart = 1'($urandom);
    roll    = $urandom_range(99);
    if (roll < 40) begin
      mode    = MODE_MATCH;
      if (roll < 36) node = alphabet[$urandom_range(5)];
      restart = ($urandom_range(9) == 0);
    end else if (roll < 60) begin
      mode = MODE_EDGE;
      if ($urandom_range(9) != 0) sidx = 10'($urandom_range(ACTIVE - 1));
      if ($urandom_range(9) == 0)
        slot = 3'($urandom_range(7, 4));
      else
        slot = pick_slot({4'b0, edge_done[sidx]}, 4);
      if ($urandom_range(9) != 0) node = alphabet[$urandom_range(5)];
      if ($urandom_range(9) != 0) tgt = 10'($urandom_range(ACTIVE - 1));
    end else if (roll < 72) begin
      mode = MODE_FAIL;
      if ($urandom_range(9) != 0) sidx = 10'($urandom_range(ACTIVE - 1, 1));
      // links only point downward, so no chain can loop
      if (sidx != 0) tgt = 10'($urandom_range(sidx - 1));
    end else begin
      mode = MODE_OUT;
      if ($urandom_range(9) != 0) sidx = 10'($urandom_range(ACTIVE - 1));
      slot = pick_slot(out_done[sidx], 8);
    end
    send_request(mode, sidx, slot, node, tgt, kmer, restart);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: root miss on empty tables, then table extremes
    send_request(MODE_MATCH, 10'd0, 3'd0, 32'h0, 10'd0, 12'd0, 1'b0);
    send_request(MODE_EDGE, 10'd0, 3'd0, 32'hFFFF_FFFF, 10'd1023, 12'd0, 1'b0);
    send_request(MODE_EDGE, 10'd0, 3'd1, 32'h0, 10'd1, 12'd0, 1'b0);
    send_request(MODE_EDGE, 10'd0, 3'd7, 32'h0, 10'd5, 12'd0, 1'b0);
    send_request(MODE_OUT, 10'd1023, 3'd0, 32'h0, 10'd0, 12'd4095, 1'b0);
    for (int i = 0; i < 8; i++)
      send_request(MODE_OUT, 10'd1, 3'(i), 32'h0, 10'd0, 12'(i * 585), 1'b0);
    send_request(MODE_MATCH, 10'd0, 3'd0, 32'hFFFF_FFFF, 10'd0, 12'd0, 1'b1);
    send_request(MODE_MATCH, 10'd0, 3'd0, 32'h0, 10'd0, 12'd0, 1'b0);
    send_request(MODE_FAIL, 10'd1023, 3'd0, 32'h0, 10'd1, 12'd0, 1'b1);
    send_request(MODE_EDGE, 10'd1, 3'd0, 32'h5, 10'd2, 12'd0, 1'b0);
    // failure-link loop between states 2 and 3
    send_request(MODE_FAIL, 10'd2, 3'd0, 32'h0, 10'd3, 12'd0, 1'b0);
    send_request(MODE_FAIL, 10'd3, 3'd0, 32'h0, 10'd2, 12'd0, 1'b0);
    send_request(MODE_MATCH, 10'd0, 3'd0, 32'h0, 10'd0, 12'd0, 1'b1);
    send_request(MODE_MATCH, 10'd0, 3'd0, 32'h5, 10'd0, 12'd0, 1'b0);
    send_request(MODE_MATCH, 10'd0, 3'd0, 32'hFFFF_FFFF, 10'd0, 12'd0, 1'b0);
    send_request(MODE_FAIL, 10'd2, 3'd0, 32'h0, 10'd0, 12'd0, 1'b0);
    send_request(MODE_FAIL, 10'd3, 3'd0, 32'h0, 10'd0, 12'd0, 1'b0);
    // chase from 1023 through its link to state 1, which has the edge
    send_request(MODE_MATCH, 10'd0, 3'd0, 32'h5, 10'd0, 12'd0, 1'b0);
    // root link is never followed
    send_request(MODE_FAIL, 10'd0, 3'd0, 32'h0, 10'd7, 12'd0, 1'b0);
    send_request(MODE_MATCH, 10'd0, 3'd0, 32'hDEAD_BEEF, 10'd0, 12'd0, 1'b0);

    repeat (100) random_request();
    wait_results_drained();

    send_idle_pct = 71;
    recv_idle_pct = 35;
    repeat (100) random_request();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (100) random_request();

    wait_results_drained();
    repeat (32) @(posedge clk);
    if (board.errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// File: files.f
sv/acm_pkg.sv
sv/acm_tables.sv
sv/aho_corasick_node_matcher.sv
test/aho_corasick_node_matcher_test.sv
